// ===== rtl/salc_pkg.sv =====
// Shared types, constants and helper functions for the set-associative LRU cache model.
// Used by every module in this folder but salc_tag_ram; depends on nothing else.
`default_nettype none

package salc_pkg;

	// Default build sizes for the top level parameters.
	localparam int MAX_SET_BITS_DEF = 6;
	localparam int MAX_WAYS_DEF     = 8;

	// Field widths fixed by the interface.
	localparam int ADDR_W  = 32;
	localparam int TAG_W   = 32;
	localparam int STAMP_W = 31;
	localparam int COUNT_W = 32;

	// Saturation limits of the stamp and statistics counters.
	localparam logic [STAMP_W-1:0] STAMP_LIMIT = 31'h7FFF_FFFF;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 32'hFFFF_FFFF;

	// Configuration register indexes.
	localparam logic [1:0] REG_SET_BITS    = 2'd0;
	localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

	// Configuration reset values.
	localparam logic [2:0] SET_BITS_RST    = 3'd4;
	localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
	localparam logic [3:0] WAYS_RST        = 4'd1;

	// Operation codes carried on the input tuser.
	localparam logic OP_SINGLE = 1'b0;
	localparam logic OP_MODIFY = 1'b1;

	// One line of the tag store.
	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// Control from the sequencer to the way compare unit.
	typedef struct packed {
		logic start;
		logic eval;
	} scan_ctl_t;

	// Statistics counter increment that sticks at its limit.
	function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] v);
		return (v == COUNT_LIMIT) ? v : v + 32'd1;
	endfunction

	// Stamp counter increment that sticks at its limit.
	function automatic logic [STAMP_W-1:0] sat_stamp(input logic [STAMP_W-1:0] v);
		return (v == STAMP_LIMIT) ? v : v + 31'd1;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/salc_cfg_regs.sv =====
// Configuration registers of the cache model with decode and range clamping.
// Depends on salc_pkg for register indexes and reset values.
`default_nettype none

module salc_cfg_regs #(
	parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
	parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
	localparam int SBW   = $clog2(MAX_SET_BITS + 1),
	localparam int WAYCW = $clog2(MAX_WAYS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [1:0]       wr_index,
	input  wire logic [4:0]       wr_data,
	output logic      [SBW-1:0]   set_bits_eff,
	output logic      [4:0]       offset_bits_eff,
	output logic      [WAYCW-1:0] ways_eff
);

	logic [2:0] set_bits_q;
	logic [4:0] offset_bits_q;
	logic [3:0] ways_q;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= salc_pkg::SET_BITS_RST;
			offset_bits_q <= salc_pkg::OFFSET_BITS_RST;
			ways_q        <= salc_pkg::WAYS_RST;
		end else if (wr_en) begin
			case (wr_index)
				salc_pkg::REG_SET_BITS:    set_bits_q    <= wr_data[2:0];
				salc_pkg::REG_OFFSET_BITS: offset_bits_q <= wr_data;
				salc_pkg::REG_WAYS_IN_USE: ways_q        <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	// Clamp the set bit count to the built maximum.
	always_comb begin
		if (32'(set_bits_q) > MAX_SET_BITS) begin
			set_bits_eff = SBW'(MAX_SET_BITS);
		end else begin
			set_bits_eff = SBW'(set_bits_q);
		end
	end

	assign offset_bits_eff = offset_bits_q;

	// Zero ways means one way; more than built means all built ways.
	always_comb begin
		if (ways_q == 4'd0) begin
			ways_eff = WAYCW'(1);
		end else if (32'(ways_q) > MAX_WAYS) begin
			ways_eff = WAYCW'(MAX_WAYS);
		end else begin
			ways_eff = WAYCW'(ways_q);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/salc_tag_ram.sv =====
// Single write port, single registered read port memory for the tag store lines.
// Generic; no package dependency.
`default_nettype none

module salc_tag_ram #(
	parameter int DEPTH = 512,
	parameter int DW    = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Write and registered read in the same cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/salc_way_cmp.sv =====
// Shared way compare unit: checks one line per cycle for a tag match, the first
// invalid way and the oldest stamp. Depends on salc_pkg for the line and control types.
`default_nettype none

module salc_way_cmp #(
	parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
	localparam int WAYW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire salc_pkg::scan_ctl_t         ctl,
	input  wire logic [WAYW-1:0]             way,
	input  wire logic [salc_pkg::TAG_W-1:0]  tag,
	input  wire salc_pkg::entry_t            line,
	output logic                             hit,
	output logic      [WAYW-1:0]             hit_way,
	output logic                             inv_found,
	output logic      [WAYW-1:0]             victim_way
);

	logic                          hit_q;
	logic                          inv_q;
	logic [WAYW-1:0]               hit_way_q;
	logic [WAYW-1:0]               inv_way_q;
	logic [WAYW-1:0]               lru_way_q;
	logic [salc_pkg::STAMP_W-1:0]  best_q;
	logic                          match;
	logic                          older;

	// One tag comparator and one stamp comparator, reused for every way.
	assign match = line.valid && (line.tag == tag);
	assign older = (way == '0) || (line.stamp < best_q);

	// Control flags of the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			inv_q <= 1'b0;
		end else if (ctl.start) begin
			hit_q <= 1'b0;
			inv_q <= 1'b0;
		end else if (ctl.eval) begin
			if (match) begin
				hit_q <= 1'b1;
			end
			if (!line.valid) begin
				inv_q <= 1'b1;
			end
		end
	end

	// Way numbers and the oldest stamp seen before the first invalid way.
	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			if (match && !hit_q) begin
				hit_way_q <= way;
			end
			if (!line.valid && !inv_q) begin
				inv_way_q <= way;
			end
			if (line.valid && !inv_q && older) begin
				best_q    <= line.stamp;
				lru_way_q <= way;
			end
		end
	end

	assign hit        = hit_q;
	assign hit_way    = hit_way_q;
	assign inv_found  = inv_q;
	assign victim_way = inv_q ? inv_way_q : lru_way_q;

endmodule

`default_nettype wire

// ===== rtl/set_assoc_lru_cache_sim.sv =====
// Set-associative LRU cache tag store model: a small sequencer around one line RAM and
// one way compare unit. Depends on salc_pkg, salc_cfg_regs, salc_tag_ram, salc_way_cmp.
//
// Each input beat is one memory access: s_tuser is the operation (single or modify) and
// s_tdata the byte address. Each access gives exactly one result beat carrying the hit
// and eviction flags of the first access and the running hit, miss and eviction totals.
// The block works on one access at a time. It reads the ways of the addressed set one per
// cycle through the single read port of the line RAM, then writes the chosen line; a modify
// writes it once more. The next access is taken only after the result has moved on.
// The result sits in an output register, so the next access is scanned while an earlier
// result waits. After reset the line RAM is cleared one line at a time over all
// 2**MAX_SET_BITS * MAX_WAYS lines (512 with the defaults), during which no access is
// taken; configuration writes are taken at all times and should be made only while no
// access is in flight.
`default_nettype none

module set_assoc_lru_cache_sim #(
	parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
	parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Access input.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] address
	input  wire logic        s_tuser,   // [0] operation
	// Result output.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [95:0] m_tdata,   // [31:0] total_hits, [63:32] total_misses,
	                                    // [95:64] total_evictions
	output logic      [1:0]  m_tuser,   // [0] was_hit, [1] was_eviction
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [4:0]  cfg_data
);

	localparam int SETS    = 1 << MAX_SET_BITS;
	localparam int LINES   = SETS * MAX_WAYS;
	localparam int LINE_AW = $clog2(LINES);
	localparam int SBW     = $clog2(MAX_SET_BITS + 1);
	localparam int WAYCW   = $clog2(MAX_WAYS + 1);
	localparam int WAYW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int ENTRY_W = $bits(salc_pkg::entry_t);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_WRITE  = 6'b001000,
		ST_MODIFY = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [LINE_AW-1:0]            clr_cnt_q;

	logic [SBW-1:0]                sb;
	logic [4:0]                    ob;
	logic [WAYCW-1:0]              nw;

	logic                          op_q;
	logic [salc_pkg::TAG_W-1:0]    tag_q;
	logic [LINE_AW-1:0]            base_q;
	logic [WAYCW-1:0]              nw_q;
	logic [WAYCW-1:0]              rd_way_q;
	logic                          eval_vld_q;
	logic [WAYW-1:0]               eval_way_q;
	logic [LINE_AW-1:0]            wr_addr_q;

	logic [salc_pkg::STAMP_W-1:0]  stamp_q;
	logic [salc_pkg::COUNT_W-1:0]  hits_q;
	logic [salc_pkg::COUNT_W-1:0]  misses_q;
	logic [salc_pkg::COUNT_W-1:0]  evicts_q;
	logic                          was_hit_q;
	logic                          was_evict_q;

	logic                          out_valid_q;
	logic [95:0]                   out_data_q;
	logic [1:0]                    out_user_q;
	logic                          out_load;

	logic                          in_beat;
	logic                          issue;
	logic [MAX_SET_BITS-1:0]       set_idx;
	logic [31:0]                   off_addr;
	logic [5:0]                    tag_shift;
	logic [63:0]                   tag_wide;
	logic [LINE_AW-1:0]            base_d;

	logic                          ram_we;
	logic [LINE_AW-1:0]            ram_waddr;
	salc_pkg::entry_t              ram_wdata;
	logic [LINE_AW-1:0]            ram_raddr;
	logic [ENTRY_W-1:0]            ram_rdata;
	salc_pkg::entry_t              rd_line;

	salc_pkg::scan_ctl_t           scan_ctl;
	logic                          sc_hit;
	logic [WAYW-1:0]               sc_hit_way;
	logic                          sc_inv;
	logic [WAYW-1:0]               sc_victim;
	logic [LINE_AW-1:0]            wr_line;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	salc_cfg_regs #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (cfg_valid),
		.wr_index        (cfg_index),
		.wr_data         (cfg_data),
		.set_bits_eff    (sb),
		.offset_bits_eff (ob),
		.ways_eff        (nw)
	);

	// Address split into set index and tag.
	assign off_addr  = s_tdata >> ob;
	assign set_idx   = off_addr[MAX_SET_BITS-1:0] & ~({MAX_SET_BITS{1'b1}} << sb);
	assign tag_shift = 6'(sb) + 6'(ob);
	assign tag_wide  = {32'd0, s_tdata} >> tag_shift;
	assign base_d    = LINE_AW'(set_idx) * LINE_AW'(MAX_WAYS);

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign issue    = (state_q == ST_SCAN) && (rd_way_q < nw_q);

	// The finished result moves into the output register once it is free.
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// Line RAM and the way compare unit.
	assign ram_raddr = base_q + LINE_AW'(rd_way_q);
	assign rd_line   = salc_pkg::entry_t'(ram_rdata);

	salc_tag_ram #(
		.DEPTH (LINES),
		.DW    (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign scan_ctl.start = in_beat;
	assign scan_ctl.eval  = (state_q == ST_SCAN) && eval_vld_q;

	salc_way_cmp #(
		.MAX_WAYS (MAX_WAYS)
	) u_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.way        (eval_way_q),
		.tag        (tag_q),
		.line       (rd_line),
		.hit        (sc_hit),
		.hit_way    (sc_hit_way),
		.inv_found  (sc_inv),
		.victim_way (sc_victim)
	);

	// Line written by the first access: the hit way or the victim.
	assign wr_line = base_q + LINE_AW'(sc_hit ? sc_hit_way : sc_victim);

	// RAM write port: clearing pass, first access and the second access of a modify.
	always_comb begin
		ram_we          = 1'b0;
		ram_waddr       = wr_line;
		ram_wdata.valid = 1'b1;
		ram_wdata.tag   = tag_q;
		ram_wdata.stamp = stamp_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			ST_WRITE: begin
				ram_we = 1'b1;
			end
			ST_MODIFY: begin
				ram_we    = 1'b1;
				ram_waddr = wr_addr_q;
			end
			default: ;
		endcase
	end

	// Sequencer, counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			rd_way_q    <= '0;
			eval_vld_q  <= 1'b0;
			stamp_q     <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + LINE_AW'(1);
					if (clr_cnt_q == LINE_AW'(LINES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					eval_vld_q <= 1'b0;
					if (in_beat) begin
						rd_way_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					eval_vld_q <= issue;
					if (issue) begin
						rd_way_q <= rd_way_q + WAYCW'(1);
					end
					if (eval_vld_q && !issue) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					eval_vld_q <= 1'b0;
					stamp_q    <= salc_pkg::sat_stamp(stamp_q);
					if (sc_hit) begin
						hits_q <= salc_pkg::sat_count(hits_q);
					end else begin
						misses_q <= salc_pkg::sat_count(misses_q);
						if (!sc_inv) begin
							evicts_q <= salc_pkg::sat_count(evicts_q);
						end
					end
					state_q <= (op_q == salc_pkg::OP_MODIFY) ? ST_MODIFY : ST_DONE;
				end
				ST_MODIFY: begin
					// The second access of a modify always hits the line just used.
					stamp_q <= salc_pkg::sat_stamp(stamp_q);
					hits_q  <= salc_pkg::sat_count(hits_q);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Access payload captured when the beat is taken; scan way, write line, flags and result.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q   <= s_tuser;
			tag_q  <= tag_wide[31:0];
			base_q <= base_d;
			nw_q   <= nw;
		end
		if (issue) begin
			eval_way_q <= rd_way_q[WAYW-1:0];
		end
		if (state_q == ST_WRITE) begin
			wr_addr_q   <= wr_line;
			was_hit_q   <= sc_hit;
			was_evict_q <= !sc_hit && !sc_inv;
		end
		if (out_load) begin
			out_data_q <= {evicts_q, misses_q, hits_q};
			out_user_q <= {was_evict_q, was_hit_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

`default_nettype wire
